@@ design/epi_pkg.sv @@
// ----------------------------------------------------------------------------
// Exact palette indexer package
// Types, constants and helpers shared by the palette indexer modules.
// ----------------------------------------------------------------------------
package epi_pkg;

    // Control sequencer states of the lookup pipeline.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_REREAD
    } t_state;

    // Frame tag kept with every table entry. Tag zero marks a swept entry.
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    // One slot table entry: frame tag and palette slot plus one.
    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [7:0]         slot;
    } t_entry;

    // Configuration register map.
    localparam int APB_ADDR_W  = 3;
    localparam int REG_IDX_BIT = 2;
    localparam logic REG_COLOUR_LIMIT = 1'b0;
    localparam logic [7:0] LIMIT_RESET = 8'd255;

    // Widen a 5-bit component to 8 bits by copying its top bits down.
    function automatic logic [7:0] widen5(input logic [4:0] v);
        widen5 = {v, v[4:2]};
    endfunction

    // Widen a 6-bit component to 8 bits by copying its top bits down.
    function automatic logic [7:0] widen6(input logic [5:0] v);
        widen6 = {v, v[5:4]};
    endfunction

endpackage

@@ design/epi_slot_ram.sv @@
// ----------------------------------------------------------------------------
// Slot table memory
// One write port and one read port, read data registered (read-first).
// ----------------------------------------------------------------------------
module epi_slot_ram #(
    parameter int ADDR_W = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_W-1:0]    i_waddr,
    input  epi_pkg::t_entry      i_wdata,
    input  logic [ADDR_W-1:0]    i_raddr,
    output epi_pkg::t_entry      o_rdata
);
    import epi_pkg::*;

    t_entry r_mem [2**ADDR_W];
    t_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/epi_apb_regs.sv @@
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style slave holding the colour limit register.
// ----------------------------------------------------------------------------
module epi_apb_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [epi_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [7:0]                      o_colour_limit
);
    import epi_pkg::*;

    logic [7:0] r_colour_limit;
    logic       w_write;
    logic       w_sel_limit;

    assign pready      = 1'b1;
    assign w_sel_limit = (paddr[REG_IDX_BIT] == REG_COLOUR_LIMIT);
    assign w_write     = psel && penable && pwrite && pready;

    // Register write; only the low byte is kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colour_limit <= LIMIT_RESET;
        end else if (w_write && w_sel_limit) begin
            r_colour_limit <= pwdata[7:0];
        end
    end

    // Read back.
    always_comb begin
        prdata = '0;
        if (w_sel_limit) begin
            prdata = {24'd0, r_colour_limit};
        end
    end

    assign o_colour_limit = r_colour_limit;

endmodule

@@ design/exact_palette_indexer.sv @@
// ----------------------------------------------------------------------------
// Exact palette indexer
// Assigns palette slots to distinct RGB565 colours per frame and widens
// every pixel to 8-bit blue, green and red.
// ----------------------------------------------------------------------------
//  Channel   | Handshake                    | Beat contents
//  ----------+------------------------------+--------------------------------
//  pixel in  | start, busy                  | pixel colour, frame start
//  result    | o_done (one-cycle strobe)    | index, first seen, overflow,
//            |                              | colours used, blue/green/red
//  config    | psel, penable, pwrite, pready| colour limit at byte address 0
//
//  A pixel beat is taken every cycle while busy is low; the cycle after a
//  frame start beat is a bubble while the frame tag advances. A beat passes
//  the lookup stage register and the result registers before its strobe.
//  Table entries carry a frame tag, so a frame start costs no sweep; after
//  reset, and once every 255 frames when the tag wraps, the table is swept
//  at one entry per cycle over all 2**COLOUR_BITS entries with busy high.
//  The single read port is registered; a write forwarded from the previous
//  pixel covers back-to-back repeats of a colour.
// ----------------------------------------------------------------------------
module exact_palette_indexer #(
    parameter int COLOUR_BITS   = 16,
    parameter int PALETTE_SLOTS = 255
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [15:0]                     i_pixel_colour,
    input  logic                            i_frame_start,
    output logic                            o_done,
    output logic [7:0]                      o_palette_index,
    output logic                            o_first_seen,
    output logic                            o_palette_overflow,
    output logic [7:0]                      o_colours_used,
    output logic [7:0]                      o_blue_out,
    output logic [7:0]                      o_green_out,
    output logic [7:0]                      o_red_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [epi_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import epi_pkg::*;

    localparam int ADDR_W = COLOUR_BITS;
    localparam logic [7:0] SLOT_CAP = 8'(PALETTE_SLOTS);

    t_state              r_state;
    t_state              n_state;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic                r_s1_valid;
    logic                r_s1_fs;
    logic [15:0]         r_s1_pix;
    logic                r_hold;
    logic [EPOCH_W-1:0]  r_epoch;
    logic [7:0]          r_count;
    logic                r_ovf;
    logic                r_fwd_valid;
    logic [ADDR_W-1:0]   r_fwd_addr;
    t_entry              r_fwd_data;
    logic                r_done;
    logic [7:0]          r_index;
    logic                r_first;
    logic                r_ovf_out;
    logic [7:0]          r_used;
    logic [7:0]          r_blue;
    logic [7:0]          r_green;
    logic [7:0]          r_red;

    logic [7:0]          w_limit_reg;
    logic [7:0]          w_limit;
    logic                w_accept;
    logic                w_wrap;
    logic                w_proc;
    logic [ADDR_W-1:0]   w_s1_addr;
    logic [EPOCH_W-1:0]  w_epoch_eff;
    logic [7:0]          w_count_eff;
    logic                w_ovf_eff;
    t_entry              w_entry;
    t_entry              w_new_entry;
    logic                w_hit;
    logic                w_add;
    logic                w_ovf_new;
    logic [7:0]          w_count_new;
    logic [7:0]          w_slot;
    logic [7:0]          w_index;
    logic                w_ram_we;
    logic [ADDR_W-1:0]   w_ram_waddr;
    t_entry              w_ram_wdata;
    logic [ADDR_W-1:0]   w_ram_raddr;
    t_entry              w_ram_rdata;

    // Configuration registers.
    epi_apb_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_colour_limit (w_limit_reg)
    );

    // Slot table.
    epi_slot_ram #(
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Active limit is the smaller of the register and the slot capacity.
    assign w_limit = (w_limit_reg > SLOT_CAP) ? SLOT_CAP : w_limit_reg;

    // Input handshake. A frame start beat blocks the next cycle.
    assign busy     = (r_state != ST_RUN) || (r_s1_valid && r_s1_fs);
    assign w_accept = start && !busy;

    // Lookup stage: a frame start on the last tag forces a sweep first.
    assign w_s1_addr = ADDR_W'(r_s1_pix);
    assign w_wrap    = (r_state == ST_RUN) && r_s1_valid && r_s1_fs &&
                       (r_epoch == EPOCH_LAST);
    assign w_proc    = (r_state == ST_RUN) && r_s1_valid && !w_wrap;

    // Palette decision for the pixel in the lookup stage.
    always_comb begin
        w_epoch_eff = r_s1_fs ? (r_epoch + EPOCH_W'(1)) : r_epoch;
        w_count_eff = r_s1_fs ? 8'd0 : r_count;
        w_ovf_eff   = r_s1_fs ? 1'b0 : r_ovf;
        w_entry     = (r_fwd_valid && (r_fwd_addr == w_s1_addr)) ? r_fwd_data
                                                                : w_ram_rdata;
        w_hit       = (w_entry.epoch == w_epoch_eff);
        w_add       = !w_ovf_eff && !w_hit && (w_count_eff < w_limit);
        w_ovf_new   = w_ovf_eff || (!w_hit && (w_count_eff >= w_limit));
        w_count_new = w_add ? (w_count_eff + 8'd1) : w_count_eff;
        w_slot      = w_hit ? w_entry.slot : w_count_new;
        w_index     = w_ovf_new ? 8'd0 : (w_slot - 8'd1);
        w_new_entry.epoch = w_epoch_eff;
        w_new_entry.slot  = w_count_new;
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = r_hold ? ST_REREAD : ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_wrap) begin
                    n_state = ST_CLEAR;
                end
            end
            ST_REREAD: begin
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Memory port control for each state.
    always_comb begin
        w_ram_raddr = ADDR_W'(i_pixel_colour);
        w_ram_we    = 1'b0;
        w_ram_waddr = w_s1_addr;
        w_ram_wdata = w_new_entry;
        case (r_state)
            ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_addr;
                w_ram_wdata = '0;
            end
            ST_RUN: begin
                w_ram_we = w_proc && w_add;
            end
            ST_REREAD: begin
                w_ram_raddr = w_s1_addr;
            end
            default: begin
                w_ram_we = 1'b0;
            end
        endcase
    end

    // Control registers and frame state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_s1_fs     <= 1'b0;
            r_hold      <= 1'b0;
            r_epoch     <= EPOCH_FIRST;
            r_count     <= 8'd0;
            r_ovf       <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_done      <= w_proc;
            r_fwd_valid <= w_proc && w_add;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            // Lookup stage occupancy; a held pixel is read again after a sweep.
            if (w_accept) begin
                r_s1_valid <= 1'b1;
                r_s1_fs    <= i_frame_start;
            end else if (r_state == ST_REREAD) begin
                r_s1_valid <= 1'b1;
                r_hold     <= 1'b0;
            end else if (w_wrap) begin
                r_s1_valid <= 1'b0;
                r_s1_fs    <= 1'b0;
                r_hold     <= 1'b1;
            end else begin
                r_s1_valid <= 1'b0;
            end
            // Frame state: the wrapping frame start is applied before the sweep.
            if (w_wrap) begin
                r_epoch <= EPOCH_FIRST;
                r_count <= 8'd0;
                r_ovf   <= 1'b0;
            end else if (w_proc) begin
                r_epoch <= w_epoch_eff;
                r_count <= w_count_new;
                r_ovf   <= w_ovf_new;
            end
        end
    end

    // Payload registers: lookup stage pixel, forwarded write, result beat.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pix <= i_pixel_colour;
        end
        r_fwd_addr <= w_s1_addr;
        r_fwd_data <= w_new_entry;
        if (w_proc) begin
            r_index   <= w_index;
            r_first   <= w_add;
            r_ovf_out <= w_ovf_new;
            r_used    <= w_count_new;
            r_blue    <= widen5(r_s1_pix[4:0]);
            r_green   <= widen6(r_s1_pix[10:5]);
            r_red     <= widen5(r_s1_pix[15:11]);
        end
    end

    assign o_done             = r_done;
    assign o_palette_index    = r_index;
    assign o_first_seen       = r_first;
    assign o_palette_overflow = r_ovf_out;
    assign o_colours_used     = r_used;
    assign o_blue_out         = r_blue;
    assign o_green_out        = r_green;
    assign o_red_out          = r_red;

endmodule

@@ design/epi_checker.sv @@
// ----------------------------------------------------------------------------
// Palette indexer checker
// Port-level properties of the result beats, bound to the top level.
// ----------------------------------------------------------------------------
module epi_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       busy,
    input  logic       o_done,
    input  logic [7:0] o_palette_index,
    input  logic       o_first_seen,
    input  logic       o_palette_overflow,
    input  logic [7:0] o_colours_used
);

    // Reset starts a table sweep, so no beat is taken right after it.
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    // A new entry is never reported together with an overflowed frame.
    a_new_not_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_first_seen) |-> !o_palette_overflow)
        else $error("new entry reported in an overflowed frame");

    // An overflowed frame reports index zero and no new entry.
    a_overflow_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_palette_overflow) |-> (o_palette_index == 8'd0 && !o_first_seen))
        else $error("overflowed frame gives a nonzero index or a new entry");

    // A new entry takes the highest slot in use.
    a_new_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_first_seen) |-> (o_palette_index == (o_colours_used - 8'd1)))
        else $error("new entry not placed in the next free slot");

    // Without overflow every pixel has a palette entry.
    a_used_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_palette_overflow) |-> (o_colours_used != 8'd0))
        else $error("indexed pixel with an empty palette");

endmodule

bind exact_palette_indexer epi_checker u_epi_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .busy               (busy),
    .o_done             (o_done),
    .o_palette_index    (o_palette_index),
    .o_first_seen       (o_first_seen),
    .o_palette_overflow (o_palette_overflow),
    .o_colours_used     (o_colours_used)
);
